// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; clocked on clk, disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define NMEA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

`define NMEA_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define NMEA_ASSERT(lbl, prop)

`define NMEA_NEVER(lbl, expr)

`endif

`endif

// ----- hw/rtl/nmea_pe_pkg.sv -----
package nmea_pe_pkg;

  localparam int MAX_LINE_DEF    = 100;
  localparam int FRAC_DIGITS_DEF = 4;
  localparam int FIFO_DEPTH      = 8;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_S     = "S";
  localparam logic [7:0] CH_W     = "W";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";

  localparam logic [47:0] HDR_RMC = "$GPRMC";
  localparam logic [47:0] HDR_GGA = "$GPGGA";

  // minute digit accumulation saturates like the sentence source expects
  localparam logic [33:0] MIN_THR = 34'd999999999;
  localparam logic [33:0] MIN_CAP = 34'd9999999999;
  // micro-minutes at 180 degrees: at or above this every result saturates
  localparam logic [33:0] XC      = 34'd10800000000;
  // ceil(2^35 / 15)
  localparam logic [31:0] RECIP15 = 32'h88888889;

  localparam logic [30:0] LAT_LIMIT = 31'd90000000;
  localparam logic [30:0] LON_LIMIT = 31'd180000000;

  typedef struct packed {
    logic [9:0]  deg;
    logic [33:0] mins;
    logic [2:0]  cnt;
    logic        minstop;
    logic        infrac;
    logic        degstop;
    logic        neg;
    logic        nonempty;
  } coord_t;

  function automatic logic [19:0] pow10(input logic [2:0] k);
    logic [19:0] p;
    begin
      case (k)
        3'd0:    p = 20'd1;
        3'd1:    p = 20'd10;
        3'd2:    p = 20'd100;
        3'd3:    p = 20'd1000;
        3'd4:    p = 20'd10000;
        3'd5:    p = 20'd100000;
        default: p = 20'd1000000;
      endcase
      pow10 = p;
    end
  endfunction

  // smallest minute value that reaches XC once scaled by 10^k
  function automatic logic [33:0] sat_thr(input logic [2:0] k);
    logic [33:0] t;
    begin
      case (k)
        3'd0:    t = 34'd10800000000;
        3'd1:    t = 34'd1080000000;
        3'd2:    t = 34'd108000000;
        3'd3:    t = 34'd10800000;
        3'd4:    t = 34'd1080000;
        3'd5:    t = 34'd108000;
        default: t = 34'd10800;
      endcase
      sat_thr = t;
    end
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [2:0] pos, input logic gga);
    logic [47:0] s;
    logic [7:0]  b;
    begin
      s = gga ? HDR_GGA : HDR_RMC;
      case (pos)
        3'd0:    b = s[47:40];
        3'd1:    b = s[39:32];
        3'd2:    b = s[31:24];
        3'd3:    b = s[23:16];
        3'd4:    b = s[15:8];
        default: b = s[7:0];
      endcase
      hdr_byte = b;
    end
  endfunction

  function automatic logic [33:0] min_digit(input logic [33:0] m, input logic [3:0] d);
    begin
      if (m >= MIN_THR) min_digit = MIN_CAP;
      else min_digit = m * 34'd10 + 34'(d);
    end
  endfunction

  function automatic coord_t feed_coord(input coord_t co, input logic [7:0] c,
                                        input logic [1:0] fci, input logic [1:0] deglen,
                                        input logic [2:0] fd);
    coord_t     f;
    logic       digit;
    logic [3:0] d;
    begin
      f = co;
      f.nonempty = 1'b1;
      digit = (c >= CH_0) && (c <= CH_9);
      d = digit ? 4'(c - CH_0) : 4'd0;
      if (fci < deglen) begin
        if (!f.degstop) begin
          if (digit) f.deg = f.deg * 10'd10 + 10'(d);
          else f.degstop = 1'b1;
        end
      end else if (!f.minstop) begin
        if (digit) begin
          if (f.infrac) begin
            if (f.cnt < fd) begin
              f.mins = min_digit(f.mins, d);
              f.cnt  = f.cnt + 3'd1;
            end
          end else begin
            f.mins = min_digit(f.mins, d);
          end
        end else if (c == CH_DOT && !f.infrac) begin
          f.infrac = 1'b1;
        end else begin
          f.minstop = 1'b1;
        end
      end
      feed_coord = f;
    end
  endfunction

endpackage

// ----- hw/rtl/nmea_position_extractor.sv -----
// NMEA position extractor.
// Slave stream: one received character per item in s_axis_tdata[7:0].
// Lines starting $GPRMC or $GPGGA are parsed as they arrive; at the newline a
// line with nonempty latitude and longitude fields gives one result item on
// the master stream: signed microdegrees, saturated to 90 / 180 degrees.
// A character is taken every cycle while s_axis_tready is high; parsing is a
// single registered update. The coordinate conversion is a three-stage pipeline
// (scale by a power of ten, divide by 60 through a reciprocal multiply, add
// degrees and saturate) feeding an eight-entry output queue; a result passes
// the stage registers and is written to the queue before it is presented.
// s_axis_tready drops only while eight results are in flight or queued, so
// a stalled receiver holds back the input once pipeline and queue hold eight.
// Reset clears the line state, the pipeline and the queue; the first byte
// after reset starts a new line.
`include "assert_macros.svh"

module nmea_position_extractor #(
  parameter int MAX_LINE    = nmea_pe_pkg::MAX_LINE_DEF,
  parameter int FRAC_DIGITS = nmea_pe_pkg::FRAC_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [27:0] latitude_udeg, [56:28] longitude_udeg
  output logic [0:0]  m_axis_tuser    // [0] sentence_kind
);

  localparam int LPW = $clog2(MAX_LINE);
  localparam int PW  = $clog2(nmea_pe_pkg::FIFO_DEPTH);
  localparam logic [2:0] FD = 3'((FRAC_DIGITS > 6) ? 6 : FRAC_DIGITS);
  localparam int EW = 58;

  logic                in_acc, out_acc;
  logic [LPW-1:0]      line_pos, line_pos_next;
  logic [1:0]          hdr_cand, hdr_cand_next;
  logic [2:0]          comma_cnt, comma_cnt_next;
  logic [1:0]          fci, fci_next;
  nmea_pe_pkg::coord_t lat, lat_next, lon, lon_next;
  logic                emit;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  always_comb begin
    logic [2:0] base;
    base           = hdr_cand[1] ? 3'd2 : 3'd3;
    line_pos_next  = line_pos;
    hdr_cand_next  = hdr_cand;
    comma_cnt_next = comma_cnt;
    fci_next       = fci;
    lat_next       = lat;
    lon_next       = lon;
    emit           = 1'b0;
    if (in_acc) begin
      if (s_axis_tdata == nmea_pe_pkg::CH_LF) begin
        emit = (line_pos >= LPW'(6)) && (hdr_cand != 2'b00) && lat.nonempty && lon.nonempty;
        line_pos_next  = '0;
        hdr_cand_next  = 2'b11;
        comma_cnt_next = '0;
        fci_next       = '0;
        lat_next       = '0;
        lon_next       = '0;
      end else if (line_pos >= LPW'(MAX_LINE - 1)) begin
        line_pos_next = line_pos;
      end else if (s_axis_tdata == nmea_pe_pkg::CH_NUL) begin
        line_pos_next = LPW'(MAX_LINE - 1);
      end else begin
        line_pos_next = line_pos + LPW'(1);
        if (line_pos < LPW'(6)) begin
          if (s_axis_tdata != nmea_pe_pkg::hdr_byte(line_pos[2:0], 1'b0))
            hdr_cand_next[0] = 1'b0;
          if (s_axis_tdata != nmea_pe_pkg::hdr_byte(line_pos[2:0], 1'b1))
            hdr_cand_next[1] = 1'b0;
        end else if (hdr_cand != 2'b00) begin
          if (s_axis_tdata == nmea_pe_pkg::CH_COMMA) begin
            if (comma_cnt != 3'd7) comma_cnt_next = comma_cnt + 3'd1;
            fci_next = '0;
          end else begin
            if (comma_cnt == base) begin
              lat_next = nmea_pe_pkg::feed_coord(lat, s_axis_tdata, fci, 2'd2, FD);
            end else if (comma_cnt == base + 3'd1) begin
              if (fci == 2'd0 && s_axis_tdata == nmea_pe_pkg::CH_S) lat_next.neg = 1'b1;
            end else if (comma_cnt == base + 3'd2) begin
              lon_next = nmea_pe_pkg::feed_coord(lon, s_axis_tdata, fci, 2'd3, FD);
            end else if (comma_cnt == base + 3'd3) begin
              if (fci == 2'd0 && s_axis_tdata == nmea_pe_pkg::CH_W) lon_next.neg = 1'b1;
            end
            if (fci != 2'd3) fci_next = fci + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos  <= '0;
      hdr_cand  <= 2'b11;
      comma_cnt <= '0;
      fci       <= '0;
      lat       <= '0;
      lon       <= '0;
    end else begin
      line_pos  <= line_pos_next;
      hdr_cand  <= hdr_cand_next;
      comma_cnt <= comma_cnt_next;
      fci       <= fci_next;
      lat       <= lat_next;
      lon       <= lon_next;
    end
  end

  // conversion pipeline, index 0 latitude, 1 longitude
  logic                s1_valid, s2_valid, s3_valid;
  logic                s1_kind, s2_kind, s3_kind;
  nmea_pe_pkg::coord_t s1_co [2];
  logic [33:0]         s2_x [2];
  logic [29:0]         s2_degp [2];
  logic                s2_neg [2];
  logic [27:0]         s3_q [2];
  logic [29:0]         s3_degp [2];
  logic                s3_neg [2];

  logic [2:0]  k1 [2];
  logic [53:0] mprod [2];
  logic [33:0] x1 [2];
  logic [33:0] xr [2];
  logic [63:0] qp [2];
  logic [30:0] tot [2];
  logic [30:0] tsat [2];
  logic [30:0] val [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      k1[i]    = 3'd6 - s1_co[i].cnt;
      mprod[i] = 54'(s1_co[i].mins) * 54'(nmea_pe_pkg::pow10(k1[i]));
      x1[i]    = (s1_co[i].mins >= nmea_pe_pkg::sat_thr(k1[i])) ? nmea_pe_pkg::XC
                                                                  : mprod[i][33:0];
      xr[i]    = s2_x[i] + 34'd30;
      qp[i]    = 64'(xr[i][33:2]) * 64'(nmea_pe_pkg::RECIP15);
      tot[i]   = 31'(s3_degp[i]) + 31'(s3_q[i]);
      tsat[i]  = (i == 0) ? ((tot[i] > nmea_pe_pkg::LAT_LIMIT) ? nmea_pe_pkg::LAT_LIMIT : tot[i])
                          : ((tot[i] > nmea_pe_pkg::LON_LIMIT) ? nmea_pe_pkg::LON_LIMIT : tot[i]);
      val[i]   = s3_neg[i] ? (31'd0 - tsat[i]) : tsat[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= emit;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_co[0] <= lat;
    s1_co[1] <= lon;
    s1_kind  <= hdr_cand[1];
    s2_kind  <= s1_kind;
    s3_kind  <= s2_kind;
    for (int i = 0; i < 2; i++) begin
      s2_x[i]    <= x1[i];
      s2_degp[i] <= 30'(s1_co[i].deg) * 30'd1000000;
      s2_neg[i]  <= s1_co[i].neg;
      s3_q[i]    <= qp[i][62:35];
      s3_degp[i] <= s2_degp[i];
      s3_neg[i]  <= s2_neg[i];
    end
  end

  // output queue
  logic [EW-1:0] fifo_mem [nmea_pe_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fifo_cnt, pending;
  logic [EW-1:0] head;
  logic [27:0]   out_lat;
  logic [28:0]   out_lon;

  always_ff @(posedge clk) begin
    if (s3_valid) fifo_mem[wr_ptr] <= {s3_kind, val[1][28:0], val[0][27:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pending  <= '0;
    end else begin
      if (s3_valid) wr_ptr <= wr_ptr + PW'(1);
      if (out_acc) rd_ptr <= rd_ptr + PW'(1);
      fifo_cnt <= fifo_cnt + (PW+1)'(s3_valid) - (PW+1)'(out_acc);
      pending  <= pending + (PW+1)'(emit) - (PW+1)'(out_acc);
    end
  end

  assign head          = fifo_mem[rd_ptr];
  assign out_lat       = head[27:0];
  assign out_lon       = head[56:28];
  assign s_axis_tready = (pending < (PW+1)'(nmea_pe_pkg::FIFO_DEPTH));
  assign m_axis_tvalid = (fifo_cnt != '0);
  assign m_axis_tdata  = {7'd0, out_lon, out_lat};
  assign m_axis_tuser  = head[57];

  `NMEA_ASSERT(a_pending_tally, pending == fifo_cnt + (PW+1)'(s1_valid) + (PW+1)'(s2_valid) + (PW+1)'(s3_valid))
  `NMEA_ASSERT(a_line_clear, (in_acc && s_axis_tdata == nmea_pe_pkg::CH_LF) |=> (line_pos == '0 && hdr_cand == 2'b11))
  `NMEA_ASSERT(a_lat_range, m_axis_tvalid |-> ($signed(out_lat) >= -28'sd90000000 && $signed(out_lat) <= 28'sd90000000))
  `NMEA_ASSERT(a_lon_range, m_axis_tvalid |-> ($signed(out_lon) >= -29'sd180000000 && $signed(out_lon) <= 29'sd180000000))
  `NMEA_NEVER(a_emit_without_header, emit && hdr_cand == 2'b00)

endmodule

// ----- sim/tb_nmea_position_extractor.sv -----
`timescale 1ns / 100ps

module tb_nmea_position_extractor;

  localparam int LINE_LIMIT = nmea_pe_pkg::MAX_LINE_DEF;
  localparam int FRAC = nmea_pe_pkg::FRAC_DIGITS_DEF;
  localparam longint unsigned MINUTE_CAP = 64'd9999999999;
  localparam longint unsigned LAT_MAX_UDEG = 64'd90000000;
  localparam longint unsigned LON_MAX_UDEG = 64'd180000000;
  localparam int RANDOM_BYTES = 200;

  typedef struct {
    int unsigned     deg;
    longint unsigned mins;
    int unsigned     frac_cnt;
    bit              nonempty;
    bit              neg;
    bit              degstop;
    bit              infrac;
    bit              minstop;
  } coord_acc_t;

  typedef struct packed {
    logic [27:0] lat;
    logic [28:0] lon;
    logic        kind;
  } fix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  fix_t pending_fixes[$];
  int   bytes_sent = 0;
  int   errors = 0;
  bit   no_gaps = 1'b0;
  int   stall_request = 0;
  int   stall_left = 0;

  // sentence tracking state
  int unsigned line_pos, commas, field_idx;
  bit [1:0]    cand;  // [0] RMC still possible, [1] GGA still possible
  coord_acc_t  lat_acc, lon_acc;

  nmea_position_extractor DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic void restart_line();
    line_pos = 0;
    cand = 2'b11;
    commas = 0;
    field_idx = 0;
    lat_acc = '{default: 0};
    lon_acc = '{default: 0};
  endfunction

  function automatic longint unsigned push_minute_digit(longint unsigned m, int unsigned d);
    if (m >= MINUTE_CAP / 10) return MINUTE_CAP;
    return m * 10 + d;
  endfunction

  function automatic coord_acc_t absorb_coord(coord_acc_t co, logic [7:0] c,
                                              int unsigned deg_len);
    bit          is_digit;
    int unsigned d;
    is_digit = (c >= nmea_pe_pkg::CH_0) && (c <= nmea_pe_pkg::CH_9);
    d = is_digit ? int'(c - nmea_pe_pkg::CH_0) : 0;
    co.nonempty = 1'b1;
    if (field_idx < deg_len) begin
      if (!co.degstop) begin
        if (is_digit) co.deg = co.deg * 10 + d;
        else co.degstop = 1'b1;
      end
    end else if (!co.minstop) begin
      if (is_digit) begin
        if (!co.infrac) begin
          co.mins = push_minute_digit(co.mins, d);
        end else if (co.frac_cnt < FRAC) begin
          co.mins = push_minute_digit(co.mins, d);
          co.frac_cnt++;
        end
      end else if (c == nmea_pe_pkg::CH_DOT && !co.infrac) begin
        co.infrac = 1'b1;
      end else begin
        co.minstop = 1'b1;
      end
    end
    return co;
  endfunction

  function automatic longint unsigned micro_degrees(coord_acc_t co, longint unsigned limit);
    longint unsigned unit, scale, full, total;
    int unsigned     cnt;
    unit = 60;
    scale = 1;
    repeat (FRAC) unit *= 10;
    cnt = (co.frac_cnt > FRAC) ? FRAC : co.frac_cnt;
    repeat (FRAC - cnt) scale *= 10;
    full = co.mins * scale;
    if (full > unit * 1000) full = unit * 1000;
    total = 64'(co.deg) * 1000000 + (full * 1000000 + unit / 2) / unit;
    if (total > limit) total = limit;
    return co.neg ? (64'd0 - total) : total;
  endfunction

  function automatic void track_byte(logic [7:0] c);
    int unsigned p, base;
    fix_t        fx;
    if (c == nmea_pe_pkg::CH_LF) begin
      if (line_pos >= 6 && cand != 2'b00 && lat_acc.nonempty && lon_acc.nonempty) begin
        fx.lat = 28'(micro_degrees(lat_acc, LAT_MAX_UDEG));
        fx.lon = 29'(micro_degrees(lon_acc, LON_MAX_UDEG));
        fx.kind = cand[1];
        pending_fixes.push_back(fx);
      end
      restart_line();
      return;
    end
    if (line_pos >= LINE_LIMIT - 1) return;
    if (c == nmea_pe_pkg::CH_NUL) begin
      line_pos = LINE_LIMIT - 1;
      return;
    end
    p = line_pos;
    line_pos = p + 1;
    if (p < 6) begin
      if (c != nmea_pe_pkg::HDR_RMC[47 - 8 * p -: 8]) cand[0] = 1'b0;
      if (c != nmea_pe_pkg::HDR_GGA[47 - 8 * p -: 8]) cand[1] = 1'b0;
      return;
    end
    if (cand == 2'b00) return;
    if (c == nmea_pe_pkg::CH_COMMA) begin
      if (commas < 127) commas++;
      field_idx = 0;
      return;
    end
    base = cand[1] ? 2 : 3;
    if (commas == base) begin
      lat_acc = absorb_coord(lat_acc, c, 2);
    end else if (commas == base + 1) begin
      if (field_idx == 0 && c == nmea_pe_pkg::CH_S) lat_acc.neg = 1'b1;
    end else if (commas == base + 2) begin
      lon_acc = absorb_coord(lon_acc, c, 3);
    end else if (commas == base + 3) begin
      if (field_idx == 0 && c == nmea_pe_pkg::CH_W) lon_acc.neg = 1'b1;
    end
    if (field_idx < 15) field_idx++;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!no_gaps) begin
      while ($urandom_range(99) < 16) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(nmea_pe_pkg::CH_LF);
  endtask

  function automatic string digits(int n);
    string s = "";
    repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  function automatic string random_coord(int deg_len);
    string s;
    case ($urandom_range(19))
      0: s = "";
      1: s = {digits(deg_len), digits(12), ".", digits(3)};
      2: s = {digits($urandom_range(deg_len)), "X", digits(2)};
      3: s = {digits(deg_len), digits(2), ".", digits(2), ".", digits(2)};
      4: s = {digits(deg_len), digits(2), "a", digits(2)};
      default: begin
        s = {digits(deg_len), digits($urandom_range(0, 2))};
        if ($urandom_range(3) != 0) s = {s, ".", digits($urandom_range(0, 6))};
      end
    endcase
    return s;
  endfunction

  function automatic string random_hemi(string pos, string negv);
    case ($urandom_range(7))
      0: return "";
      1: return "x";
      2: return {pos, negv};
      3, 4: return pos;
      default: return negv;
    endcase
  endfunction

  function automatic string random_sentence();
    bit    gga;
    string s;
    gga = 1'($urandom_range(1));
    if (gga) s = "$GPGGA,";
    else s = "$GPRMC,";
    s = {s, digits($urandom_range(0, 6)), ","};
    if (!gga) begin
      if ($urandom_range(1)) s = {s, "A,"};
      else s = {s, "V,"};
    end
    s = {s, random_coord(2), ",", random_hemi("N", "S"), ",",
         random_coord(3), ",", random_hemi("E", "W")};
    if ($urandom_range(1)) s = {s, ",1,08,0.9*47"};
    return s;
  endfunction

  task automatic test_rmc_fixes();
    send_line("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
    send_line("$GPRMC,,,0000.0000,S,00000.0000,W");
    send_line("$GPRMC,,V,8959.9999,S,17959.9999,W");
    send_line("$GPRMC,,,9999.99999,N,99999.99999,E");
  endtask

  task automatic test_gga_fixes();
    send_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    send_line("$GPGGA,,3345.1,S,15112.25,W");
    send_line("$GPGGA,,00,N,000,E");
    send_line("$GPGGA,,4807,x,01131,SW");
  endtask

  task automatic test_odd_lines();
    string pad;
    send_line("$GPR");
    send_line("");
    send_line("$GPRMC");
    send_line("$GPRMC,,,,N,01131.000,E");
    send_line("$GPGGA,,4807.038,N,,E");
    send_line("$GPRMC,,,4X07.038,N,0A131.000,E");
    send_line("$GPRMC,,,4807.0.38,N,01131a12,E");
    send_line("$GPGGA,,12123456789012.5,S,123123456789012,W");
    send_line("$GPGSV,,4807.038,N,01131.000,E");
    send_line("$gprmc,,,4807.038,N,01131.000,E");
    // NUL mid-field: longitude keeps what came before it
    send_text("$GPRMC,,,4807.038,N,011");
    send_byte(nmea_pe_pkg::CH_NUL);
    send_line("31.000,W");
    // bytes past the line limit are ignored
    pad = "";
    repeat (9) pad = {pad, "0123456789"};
    send_line({"$GPRMC,,,4807.038,S,01131.000,W,", pad});
    send_line({"$GPRMC,", pad, ",,4807,N,01131,E"});
    send_text("$GPGGA,,12");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_line(",N,0017F,E");
  endtask

  task automatic test_gapless_burst();
    no_gaps = 1'b1;
    repeat (4) send_line(random_sentence());
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    stall_request = 400;
    repeat (10) send_line({"$GPGGA,,", digits(4), ".", digits(2), ",S,",
                           digits(5), ".", digits(2), ",W"});
  endtask

  task automatic test_random_sentences();
    int    first_byte, idx;
    string line;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      line = random_sentence();
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
          if ($urandom_range(1)) send_byte(nmea_pe_pkg::CH_LF);
        end
        1: begin
          idx = $urandom_range(line.len() - 1);
          if ($urandom_range(1)) line = line.substr(0, idx);
          else line.putc(idx, 8'($urandom_range(1, 255)));
          send_line(line);
        end
        2: begin
          idx = $urandom_range(line.len() - 1);
          send_text(line.substr(0, idx));
          send_byte(nmea_pe_pkg::CH_NUL);
          send_line(line.substr(idx, line.len() - 1));
        end
        3: begin
          if ($urandom_range(3) == 0) line = {line, ",", digits($urandom_range(50, 90))};
          send_line(line);
        end
        default: send_line(line);
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin : check_fixes
    fix_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected item lat %0d lon %0d kind %0d", $time,
                 $signed(m_axis_tdata[27:0]), $signed(m_axis_tdata[56:28]),
                 m_axis_tuser[0]);
        errors++;
      end else begin
        want = pending_fixes.pop_front();
        if (m_axis_tdata[27:0] !== want.lat) begin
          $display("%0t: latitude expected %0d got %0d", $time,
                   $signed(want.lat), $signed(m_axis_tdata[27:0]));
          errors++;
        end
        if (m_axis_tdata[56:28] !== want.lon) begin
          $display("%0t: longitude expected %0d got %0d", $time,
                   $signed(want.lon), $signed(m_axis_tdata[56:28]));
          errors++;
        end
        if (m_axis_tuser[0] !== want.kind) begin
          $display("%0t: sentence kind expected %0d got %0d", $time,
                   want.kind, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb_nmea_position_extractor failed");
    $finish;
  end

  initial begin
    restart_line();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_rmc_fixes();
    test_gga_fixes();
    test_odd_lines();
    test_gapless_burst();
    test_backpressure();
    test_random_sentences();
    s_axis_tvalid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_nmea_position_extractor passed");
    else $display("tb_nmea_position_extractor failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/nmea_pe_pkg.sv
hw/rtl/nmea_position_extractor.sv
sim/tb_nmea_position_extractor.sv
